>>> rtl/sdc_pkg.sv
package sdc_pkg;

   localparam int ANGLE_BITS_DEF    = 16;
   localparam int CORDIC_STAGES_DEF = 16;

   // CORDIC datapath: Q2.30 x/y with headroom, 32-bit turn angle plus sign
   localparam int XY_W = 34;
   localparam int Z_W  = 33;
   localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032874;

   localparam int Q14_ONE = 16384;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam logic [1:0] REG_OBLIQUITY  = 2'd0;
   localparam logic [1:0] REG_ORBIT_RATE = 2'd1;
   localparam logic [1:0] REG_SPIN_RATE  = 2'd2;

   // arctangent of 2^-i in 2^-32 turns
   function automatic logic [31:0] atan_turn(input int unsigned idx);
      logic [31:0] a;
      case (idx)
         0:       a = 32'd536870912;
         1:       a = 32'd316933406;
         2:       a = 32'd167458907;
         3:       a = 32'd85004756;
         4:       a = 32'd42667331;
         5:       a = 32'd21354465;
         6:       a = 32'd10680862;
         7:       a = 32'd5340245;
         8:       a = 32'd2670163;
         9:       a = 32'd1335087;
         10:      a = 32'd667544;
         11:      a = 32'd333772;
         12:      a = 32'd166886;
         13:      a = 32'd83443;
         14:      a = 32'd41722;
         15:      a = 32'd20861;
         16:      a = 32'd10430;
         17:      a = 32'd5215;
         18:      a = 32'd2608;
         19:      a = 32'd1304;
         20:      a = 32'd652;
         21:      a = 32'd326;
         22:      a = 32'd163;
         23:      a = 32'd81;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

   // Q2.30 to Q1.14, round half up, clamp to plus or minus one
   function automatic logic signed [15:0] round_q14(input logic signed [XY_W-1:0] v);
      logic signed [XY_W-1:0] rnd;
      logic signed [XY_W-1:0] one;
      logic signed [XY_W-1:0] r;
      rnd = 34'sd32768;
      one = 34'sd16384;
      r   = (v + rnd) >>> 16;
      if (r > one) begin
         r = one;
      end else if (r < -one) begin
         r = -one;
      end
      return r[15:0];
   endfunction

endpackage

>>> rtl/sdc_delay.sv
module sdc_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d_in,
   output logic [WIDTH-1:0] q_out
);

   logic [WIDTH-1:0] stage_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff[0] <= d_in;
         for (int k = 1; k < DEPTH; k++) begin
            stage_ff[k] <= stage_ff[k-1];
         end
      end
   end

   assign q_out = stage_ff[DEPTH-1];

endmodule

>>> rtl/sdc_phase.sv
module sdc_phase #(
   parameter int ANGLE_BITS = sdc_pkg::ANGLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [31:0]           time_s,
   input  logic [47:0]           orbit_rate,
   input  logic [47:0]           hour_rate,
   output logic [ANGLE_BITS-1:0] orbit_phase,
   output logic [ANGLE_BITS-1:0] hour_phase
);

   // low 48 bits of rate*time from two 24x32 partial products
   logic [55:0]           orb_lo_ff, hr_lo_ff;
   logic [23:0]           orb_hi_ff, hr_hi_ff;
   logic [55:0]           orb_hi_in, hr_hi_in;
   logic [47:0]           orb_sum, hr_sum;
   logic [ANGLE_BITS-1:0] orbit_phase_ff, hour_phase_ff;

   assign orb_hi_in = orbit_rate[47:24] * time_s;
   assign hr_hi_in  = hour_rate[47:24] * time_s;

   always_ff @(posedge clock) begin
      if (en) begin
         orb_lo_ff <= orbit_rate[23:0] * time_s;
         hr_lo_ff  <= hour_rate[23:0] * time_s;
         orb_hi_ff <= orb_hi_in[23:0];
         hr_hi_ff  <= hr_hi_in[23:0];
      end
   end

   assign orb_sum = orb_lo_ff[47:0] + {orb_hi_ff, 24'd0};
   assign hr_sum  = hr_lo_ff[47:0] + {hr_hi_ff, 24'd0};

   always_ff @(posedge clock) begin
      if (en) begin
         orbit_phase_ff <= orb_sum[47:48-ANGLE_BITS];
         hour_phase_ff  <= hr_sum[47:48-ANGLE_BITS];
      end
   end

   assign orbit_phase = orbit_phase_ff;
   assign hour_phase  = hour_phase_ff;

endmodule

>>> rtl/sdc_cordic.sv
module sdc_cordic #(
   parameter int ANGLE_BITS    = sdc_pkg::ANGLE_BITS_DEF,
   parameter int CORDIC_STAGES = sdc_pkg::CORDIC_STAGES_DEF
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [ANGLE_BITS-1:0] angle,
   output logic signed [15:0]    sin_out,
   output logic signed [15:0]    cos_out
);

   localparam int XW = sdc_pkg::XY_W;
   localparam int ZW = sdc_pkg::Z_W;
   localparam logic signed [ZW-1:0] QUARTER = 33'sd1073741824;
   localparam logic signed [ZW-1:0] HALF    = 33'sd2147483648;

   logic signed [XW-1:0] x_ff    [0:CORDIC_STAGES];
   logic signed [XW-1:0] y_ff    [0:CORDIC_STAGES];
   logic signed [ZW-1:0] z_ff    [0:CORDIC_STAGES];
   logic                 flip_ff [0:CORDIC_STAGES];

   logic [31:0]          z32;
   logic signed [ZW-1:0] z_ext;
   logic signed [ZW-1:0] z_in;
   logic                 flip_in;
   logic signed [15:0]   sin_ff, cos_ff;

   assign z32   = {angle, {(32-ANGLE_BITS){1'b0}}};
   assign z_ext = $signed({z32[31], z32});

   // fold into a quarter turn around zero, flip the result back later
   always_comb begin
      z_in    = z_ext;
      flip_in = 1'b0;
      if (z_ext > QUARTER) begin
         z_in    = z_ext - HALF;
         flip_in = 1'b1;
      end else if (z_ext < -QUARTER) begin
         z_in    = z_ext + HALF;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= sdc_pkg::CORDIC_X0;
         y_ff[0]    <= '0;
         z_ff[0]    <= z_in;
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
      localparam logic signed [ZW-1:0] ATAN = $signed({1'b0, sdc_pkg::atan_turn(i)});
      always_ff @(posedge clock) begin
         if (en) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN;
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN;
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (flip_ff[CORDIC_STAGES]) begin
            sin_ff <= sdc_pkg::round_q14(-y_ff[CORDIC_STAGES]);
            cos_ff <= sdc_pkg::round_q14(-x_ff[CORDIC_STAGES]);
         end else begin
            sin_ff <= sdc_pkg::round_q14(y_ff[CORDIC_STAGES]);
            cos_ff <= sdc_pkg::round_q14(x_ff[CORDIC_STAGES]);
         end
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

>>> rtl/sdc_combine.sv
module sdc_combine (
   input  logic               clock,
   input  logic               en,
   input  logic signed [15:0] sin_lat,
   input  logic signed [15:0] cos_lat,
   input  logic signed [15:0] sin_dec,
   input  logic signed [15:0] cos_dec,
   input  logic signed [15:0] cos_hour,
   output logic signed [15:0] cos_zenith
);

   localparam logic signed [48:0] RND  = 49'sd134217728;
   localparam logic signed [48:0] ONE  = 49'sd16384;

   logic signed [31:0] ss_ff, cc_ff, ss2_ff;
   logic signed [15:0] ch_ff;
   logic signed [47:0] ccc_ff;
   logic signed [48:0] sum;
   logic signed [48:0] res;
   logic signed [15:0] cos_zenith_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ss_ff  <= sin_lat * sin_dec;
         cc_ff  <= cos_lat * cos_dec;
         ch_ff  <= cos_hour;
         ss2_ff <= ss_ff;
         ccc_ff <= cc_ff * ch_ff;
      end
   end

   // Q42 sum, round to Q14 and clamp
   always_comb begin
      sum = $signed({{3{ss2_ff[31]}}, ss2_ff, 14'd0}) + $signed({ccc_ff[47], ccc_ff}) + RND;
      res = sum >>> 28;
      if (res > ONE) begin
         res = ONE;
      end else if (res < -ONE) begin
         res = -ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_zenith_ff <= res[15:0];
      end
   end

   assign cos_zenith = cos_zenith_ff;

endmodule

>>> rtl/solar_zenith_cosine.sv
// Solar zenith cosine. Each request transaction carries a time in seconds and
// a latitude and longitude as signed binary angles (turns * 65536); each
// response transaction returns the cosine of the star's zenith angle in Q1.14,
// clamped to plus or minus one. The block is a straight pipeline: it takes one
// transaction every clock while its responses are taken, and it holds two
// CORDIC rotation pipelines in series: the first gives the sine of the orbital
// phase for the declination, the second runs three rotators side by side for
// the latitude, declination and hour angle. A response that is not taken holds
// the whole pipeline; nothing is dropped or repeated. The three registers
// (obliquity at 0x00, orbit rate at 0x08, spin rate at 0x10) are to be written
// through the APB-style port only while no transaction is in flight; the block
// itself does not enforce this. Rates are in 2^-48 turns per second; 0 means
// no orbit or no spin.
module solar_zenith_cosine #(
   parameter int ANGLE_BITS    = sdc_pkg::ANGLE_BITS_DEF,
   parameter int CORDIC_STAGES = sdc_pkg::CORDIC_STAGES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [31:0]                        req_time_seconds,
   input  logic signed [15:0]                 req_latitude,
   input  logic signed [15:0]                 req_longitude,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [15:0]                 rsp_cos_zenith,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sdc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sdc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sdc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int AB      = ANGLE_BITS;
   localparam int LAT     = 2 * CORDIC_STAGES + 12;
   localparam int D2_IDX  = CORDIC_STAGES + 6;
   localparam int MW      = AB + 15;
   localparam logic [AB-1:0] HALF_TURN = {1'b1, {(AB-1){1'b0}}};

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [14:0] obliquity_ff;
   logic [47:0] orbit_rate_ff;
   logic [47:0] spin_rate_ff;
   logic [47:0] hour_rate_ff;
   logic        csr_write;
   logic [1:0]  csr_index;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:3];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         obliquity_ff  <= '0;
         orbit_rate_ff <= '0;
         spin_rate_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            sdc_pkg::REG_OBLIQUITY:  obliquity_ff  <= csr_pwdata[14:0];
            sdc_pkg::REG_ORBIT_RATE: orbit_rate_ff <= csr_pwdata[47:0];
            sdc_pkg::REG_SPIN_RATE:  spin_rate_ff  <= csr_pwdata[47:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // Hour-angle rate, precomputed so the pipeline never sees the subtract.
   always_ff @(posedge clock) begin
      if (reset) begin
         hour_rate_ff <= '0;
      end else begin
         hour_rate_ff <= spin_rate_ff - orbit_rate_ff;
      end
   end

   always_comb begin
      case (csr_index)
         sdc_pkg::REG_OBLIQUITY:  csr_prdata = {49'd0, obliquity_ff};
         sdc_pkg::REG_ORBIT_RATE: csr_prdata = {{16{orbit_rate_ff[47]}}, orbit_rate_ff};
         sdc_pkg::REG_SPIN_RATE:  csr_prdata = {{16{spin_rate_ff[47]}}, spin_rate_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Pipeline control: every stage advances together unless the response
   // register holds a result that is not taken.
   // ---------------------------------------------------------------------
   logic           pipe_en;
   logic [LAT-1:0] vld_ff;

   assign pipe_en   = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = pipe_en;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // ---------------------------------------------------------------------
   // Input stage: capture the transaction, bring angles to AB bits of a turn
   // ---------------------------------------------------------------------
   logic [AB-1:0] lat_ang, lon_ang, obl_ang;
   logic [15:0]   obl16;

   assign obl16 = {1'b0, obliquity_ff};

   if (AB > 16) begin : g_up
      assign lat_ang = {req_latitude, {(AB-16){1'b0}}};
      assign lon_ang = {req_longitude, {(AB-16){1'b0}}};
      assign obl_ang = {obl16, {(AB-16){1'b0}}};
   end else begin : g_down
      assign lat_ang = req_latitude[15:16-AB];
      assign lon_ang = req_longitude[15:16-AB];
      assign obl_ang = obl16[15:16-AB];
   end

   logic [31:0]   time_ff;
   logic [AB-1:0] lat_ff, lon_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         time_ff <= req_time_seconds;
         lat_ff  <= lat_ang;
         lon_ff  <= lon_ang;
      end
   end

   // ---------------------------------------------------------------------
   // Phases: rate * time modulo one turn
   // ---------------------------------------------------------------------
   logic [AB-1:0] orbit_phase, hour_phase;
   logic [AB-1:0] lat_s3, lon_s3;
   logic [AB-1:0] hour_ang;

   sdc_phase #(.ANGLE_BITS(AB)) u_phase (
      .clock       (clock),
      .en          (pipe_en),
      .time_s      (time_ff),
      .orbit_rate  (orbit_rate_ff),
      .hour_rate   (hour_rate_ff),
      .orbit_phase (orbit_phase),
      .hour_phase  (hour_phase)
   );

   sdc_delay #(.WIDTH(2*AB), .DEPTH(2)) u_pos_dly (
      .clock (clock),
      .en    (pipe_en),
      .d_in  ({lat_ff, lon_ff}),
      .q_out ({lat_s3, lon_s3})
   );

   // hour angle: rotation phase minus longitude plus half a turn
   assign hour_ang = hour_phase - lon_s3 + HALF_TURN;

   // ---------------------------------------------------------------------
   // Declination: obliquity times sin(orbit phase)
   // ---------------------------------------------------------------------
   logic signed [15:0] sin_orb;
   logic signed [15:0] sin_orb_neg;
   logic [14:0]        sin_orb_abs;
   logic [MW-1:0]      mag_ff;
   logic               dec_neg_ff;
   logic [MW-1:0]      mag_rnd;
   logic [AB-1:0]      dec_mag;
   logic [AB-1:0]      dec_ang_ff;

   sdc_cordic #(.ANGLE_BITS(AB), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_orb (
      .clock   (clock),
      .en      (pipe_en),
      .angle   (orbit_phase),
      .sin_out (sin_orb),
      .cos_out ()
   );

   assign sin_orb_neg = -sin_orb;
   assign sin_orb_abs = sin_orb[15] ? sin_orb_neg[14:0] : sin_orb[14:0];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         mag_ff     <= MW'(obl_ang) * MW'(sin_orb_abs);
         dec_neg_ff <= sin_orb[15];
      end
   end

   // round half away from zero by rounding the magnitude, then apply the sign
   assign mag_rnd = mag_ff + MW'(8192);
   assign dec_mag = mag_rnd[AB+13:14];

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dec_ang_ff <= dec_neg_ff ? -dec_mag : dec_mag;
      end
   end

   // ---------------------------------------------------------------------
   // Second rotation: latitude, declination and hour angle side by side
   // ---------------------------------------------------------------------
   logic [AB-1:0]      lat_d, hour_d;
   logic signed [15:0] sin_lat, cos_lat, sin_dec, cos_dec, cos_hour;

   sdc_delay #(.WIDTH(2*AB), .DEPTH(CORDIC_STAGES + 4)) u_ang_dly (
      .clock (clock),
      .en    (pipe_en),
      .d_in  ({lat_s3, hour_ang}),
      .q_out ({lat_d, hour_d})
   );

   sdc_cordic #(.ANGLE_BITS(AB), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_lat (
      .clock   (clock),
      .en      (pipe_en),
      .angle   (lat_d),
      .sin_out (sin_lat),
      .cos_out (cos_lat)
   );

   sdc_cordic #(.ANGLE_BITS(AB), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_dec (
      .clock   (clock),
      .en      (pipe_en),
      .angle   (dec_ang_ff),
      .sin_out (sin_dec),
      .cos_out (cos_dec)
   );

   sdc_cordic #(.ANGLE_BITS(AB), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_hour (
      .clock   (clock),
      .en      (pipe_en),
      .angle   (hour_d),
      .sin_out (),
      .cos_out (cos_hour)
   );

   // ---------------------------------------------------------------------
   // sin(lat)sin(dec) + cos(lat)cos(dec)cos(H); last stage is the response
   // register
   // ---------------------------------------------------------------------
   sdc_combine u_combine (
      .clock      (clock),
      .en         (pipe_en),
      .sin_lat    (sin_lat),
      .cos_lat    (cos_lat),
      .sin_dec    (sin_dec),
      .cos_dec    (cos_dec),
      .cos_hour   (cos_hour),
      .cos_zenith (rsp_cos_zenith)
   );

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_rsp_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cos_zenith <= 16'sd16384 && rsp_cos_zenith >= -16'sd16384))
      else $error("response outside plus or minus one");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during a stall");

   a_no_tilt: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[D2_IDX] && obliquity_ff == 15'd0) |-> dec_ang_ff == '0)
      else $error("nonzero declination with zero obliquity");

endmodule

>>> verif/testbench.sv
module testbench;

   localparam int LATENCY    = 2 * sdc_pkg::CORDIC_STAGES_DEF + 12;
   localparam int N_RANDOM   = 1880;
   localparam int MAX_CYCLES = 400000;
   localparam int ADDR_W     = sdc_pkg::CSR_ADDR_W;
   localparam int DATA_W     = sdc_pkg::CSR_DATA_W;

   // arctangent table in 2^-32 turns, one entry per CORDIC stage
   localparam longint ATAN_TURNS [0:15] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10680862, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861};

   class zenith_scoreboard;
      longint cos_queue[$];
      int     errors;
      int     matched;
      logic [14:0] tilt;
      logic [47:0] orbit_rate;
      logic [47:0] spin_rate;

      function new();
         errors = 0;
         matched = 0;
         tilt = '0;
         orbit_rate = '0;
         spin_rate = '0;
      endfunction

      static function longint round_to_q14(input longint q30);
         longint r;
         r = (q30 + 32768) >>> 16;
         if (r > sdc_pkg::Q14_ONE) r = sdc_pkg::Q14_ONE;
         if (r < -sdc_pkg::Q14_ONE) r = -sdc_pkg::Q14_ONE;
         return r;
      endfunction

      // rotation-mode CORDIC on a 16-bit binary angle
      static function void sin_cos(input logic [15:0] ang, output longint s,
                                   output longint c);
         longint z, x, y, dx, dy;
         bit     flip;
         z = longint'({ang, 16'h0000});
         x = 652032874;
         y = 0;
         flip = 0;
         if (z >= 64'sd2147483648) z -= 64'sd4294967296;
         if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648;
            flip = 1;
         end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648;
            flip = 1;
         end
         for (int i = 0; i < sdc_pkg::CORDIC_STAGES_DEF; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= ATAN_TURNS[i];
            end else begin
               x += dx; y -= dy; z += ATAN_TURNS[i];
            end
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         s = round_to_q14(y);
         c = round_to_q14(x);
      endfunction

      function longint zenith_cosine(input logic [31:0] t, input logic [15:0] lat,
                                     input logic [15:0] lon);
         logic [95:0] prod;
         logic [47:0] hour_rate;
         logic [15:0] orb_phase, hour_phase, hour, dec;
         longint      so, co, sl, cl, sd, cd, sh, ch, mag, decs, sum, r;
         prod = orbit_rate * t;
         orb_phase = prod[47:32];
         hour_rate = spin_rate - orbit_rate;
         prod = hour_rate * t;
         hour_phase = prod[47:32];
         sin_cos(orb_phase, so, co);
         mag = longint'(tilt[14:0]) * (so < 0 ? -so : so);
         decs = (mag + 8192) >>> 14;
         if (so < 0) decs = -decs;
         dec = decs[15:0];
         hour = hour_phase - lon + 16'h8000;
         sin_cos(lat, sl, cl);
         sin_cos(dec, sd, cd);
         sin_cos(hour, sh, ch);
         sum = sl * sd * sdc_pkg::Q14_ONE + cl * cd * ch;
         r = (sum + (64'sd1 <<< 27)) >>> 28;
         if (r > sdc_pkg::Q14_ONE) r = sdc_pkg::Q14_ONE;
         if (r < -sdc_pkg::Q14_ONE) r = -sdc_pkg::Q14_ONE;
         return r;
      endfunction

      function void note_request(input logic [31:0] t, input logic [15:0] lat,
                                 input logic [15:0] lon);
         cos_queue.push_back(zenith_cosine(t, lat, lon));
      endfunction

      function void check_response(input logic signed [15:0] got);
         longint want;
         if (cos_queue.size() == 0) begin
            errors++;
            $display("%0t: unexpected response cos_zenith=%0d", $time, got);
            return;
         end
         want = cos_queue.pop_front();
         if (longint'(got) != want) begin
            errors++;
            $display("%0t: cos_zenith mismatch expected=%0d actual=%0d",
                     $time, want, got);
         end else begin
            matched++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [31:0] req_time_seconds = '0;
   logic signed [15:0] req_latitude = '0;
   logic signed [15:0] req_longitude = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [15:0] rsp_cos_zenith;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0] csr_pwdata = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic csr_pready;

   solar_zenith_cosine dut (.*);

   zenith_scoreboard board = new();
   int sender_idle_pct = 30;
   int receiver_idle_pct = 51;
   int hold_off = 0;        // cycles left in a long receiver stall
   longint cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // abort on runaway
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("%0t: timeout with %0d results outstanding", $time,
                  board.cos_queue.size());
         $display("status: fail");
         $finish;
      end
   end

   // record accepted transactions at the rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         board.note_request(req_time_seconds, req_latitude, req_longitude);
      if (!reset && rsp_valid && rsp_ready)
         board.check_response(rsp_cos_zenith);
   end

   // receiver: random stalls, or a long hold-off counted here
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // write one register with a setup phase and an access phase
   task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= ADDR_W'(idx) << 3;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         sdc_pkg::REG_OBLIQUITY:  board.tilt = value[14:0];
         sdc_pkg::REG_ORBIT_RATE: board.orbit_rate = value[47:0];
         sdc_pkg::REG_SPIN_RATE:  board.spin_rate = value[47:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   task automatic configure(input logic [14:0] tilt, input logic [47:0] orbit,
                            input logic [47:0] spin);
      write_reg(sdc_pkg::REG_OBLIQUITY, 64'(tilt));
      write_reg(sdc_pkg::REG_ORBIT_RATE, 64'(orbit));
      write_reg(sdc_pkg::REG_SPIN_RATE, 64'(spin));
   endtask

   // offer one transaction; hold it until accepted
   task automatic send_request(input logic [31:0] t, input logic [15:0] lat,
                               input logic [15:0] lon);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_time_seconds <= t;
      req_latitude <= lat;
      req_longitude <= lon;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.cos_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   function automatic logic [15:0] rand_latitude();
      case ($urandom_range(3))
         0: return 16'($signed($urandom_range(32768)) - 16384);
         1: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [47:0] rand_rate();
      case ($urandom_range(4))
         0: return '0;
         1: return 48'($urandom);
         2: return 48'({$urandom, $urandom} >> $urandom_range(47));
         default: return 48'({$urandom, $urandom});
      endcase
   endfunction

   task automatic random_burst(input int count);
      for (int i = 0; i < count; i++) begin
         logic [31:0] t;
         t = ($urandom_range(3) == 0) ? $urandom_range(100000) : $urandom;
         send_request(t, rand_latitude(), 16'($urandom));
      end
   endtask

   initial begin
      int phase_items;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: no spin and no orbit, extreme positions
      sender_idle_pct = 0;
      send_request(32'd0, 16'sd0, 16'sd0);
      send_request(32'hFFFF_FFFF, 16'sd16384, 16'sh7FFF);
      send_request(32'd12345, -16'sd16384, 16'sh8000);
      send_request(32'd1, 16'sh7FFF, 16'sh4000);   // latitude past a quarter turn
      send_request(32'd2, 16'sh8000, 16'shC000);
      drain();
      // spin only, then full tilt with a wrapping orbit
      configure(15'd0, 48'd0, 48'h0000_0001_0000);
      send_request(32'd3600, 16'sd4000, 16'sd0);
      send_request(32'hFFFF_FFFF, -16'sd4000, 16'sd100);
      drain();
      configure(15'h7FFF, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
      send_request(32'hFFFF_FFFF, 16'sd16384, 16'sh7FFF);
      send_request(32'h8000_0000, -16'sd16384, 16'sh8000);
      send_request(32'd77777, 16'sd0, 16'sd0);
      drain();
      configure(15'd16384, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF);
      send_request(32'd1, 16'sd8000, 16'sd1);
      send_request(32'hFFFF_FFFF, -16'sd8000, -16'sd1);
      send_request(32'h5555_5555, 16'shAAAA, 16'sh5555);
      drain();

      // random phases, each with its own register setting
      for (int ph = 0; ph < 12; ph++) begin
         if (ph < 4) begin
            sender_idle_pct = 30; receiver_idle_pct = 51;
         end else if (ph < 8) begin
            sender_idle_pct = 51; receiver_idle_pct = 30;
         end else begin
            sender_idle_pct = 0; receiver_idle_pct = 0;
         end
         configure($urandom_range(3) == 0 ? 15'($urandom) : 15'($urandom_range(16384)),
                   rand_rate(), rand_rate());
         phase_items = N_RANDOM / 12;
         if (ph == 9) begin
            // long receiver stall while requests keep coming; fills the pipe
            hold_off = 3 * LATENCY + 50;
         end
         random_burst(phase_items);
         // pause until everything is back
         drain();
      end

      $display("covered %0d checked responses over directed cases and 12 random",
               board.matched);
      $display("register settings with sender and receiver stalls");
      if (board.errors == 0 && board.cos_queue.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

>>> solar_zenith_cosine.f
rtl/sdc_pkg.sv
rtl/sdc_delay.sv
rtl/sdc_phase.sv
rtl/sdc_cordic.sv
rtl/sdc_combine.sv
rtl/solar_zenith_cosine.sv
verif/testbench.sv
